[hdl/sorted_list_table_top_defines.svh]
// Assertion macros for the sorted list table checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef SORTED_LIST_TABLE_TOP_DEFINES_SVH
`define SORTED_LIST_TABLE_TOP_DEFINES_SVH

// Clocked check, ignored while reset is asserted
`define SLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define SLT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/slt_pkg.sv]
// Shared constants, codes and control structs for the sorted list table.
// No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

	// Table geometry
	localparam int DEPTH = 16;
	localparam int CNT_W = 5;   // holds 0..DEPTH
	localparam int VAL_W = 32;
	localparam int CMD_W = 2;
	localparam int ST_W  = 3;

	// Operation codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	// Result status codes
	localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [ST_W-1:0] ST_FOUND    = 3'd1;
	localparam logic [ST_W-1:0] ST_MISSING  = 3'd2;
	localparam logic [ST_W-1:0] ST_DELETED  = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic            load;        // latch the incoming transaction
		logic            compare;     // register compare vectors
		logic            do_insert;   // shift up and write the key
		logic            do_delete;   // shift down over the first match
		logic            load_result; // capture status and count
		logic [ST_W-1:0] res_status;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             found;
		logic             full;
	} dp_stat_t;

endpackage

[hdl/sorted_list_table_top.sv]
// A transaction goes through accept, compare and apply before its result is valid.
// A new transaction is taken only after the last one is applied; the compare of all
// cells is registered before the shift; a waiting result stalls only the apply step.
// Reset (arst_n low, asynchronous): clears FSM, occupancy and output valid;
// entry cells are not cleared and are only read once written.
`timescale 1ns / 1ps

module sorted_list_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] cmd, [33:2] value, [39:34] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [2:0] status, [7:3] count
);

	slt_pkg::dp_cmd_t              dp_cmd;
	slt_pkg::dp_stat_t             dp_stat;
	logic [slt_pkg::ST_W-1:0]      res_status;
	logic [slt_pkg::CNT_W-1:0]     res_count;

	slt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	slt_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_cmd     (s_tdata[1:0]),
		.in_value   (s_tdata[33:2]),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.res_status (res_status),
		.res_count  (res_count)
	);

	assign m_tdata = {res_count, res_status};

endmodule

[hdl/slt_datapath.sv]
// Datapath of the sorted list table: entry cells, parallel compare, shifts.
// Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [slt_pkg::CMD_W-1:0]     in_cmd,
	input  logic signed [slt_pkg::VAL_W-1:0] in_value,
	input  slt_pkg::dp_cmd_t              cmd,
	output slt_pkg::dp_stat_t             stat,
	output logic [slt_pkg::ST_W-1:0]      res_status,
	output logic [slt_pkg::CNT_W-1:0]     res_count
);

	logic [slt_pkg::CMD_W-1:0]        op_q;
	logic signed [slt_pkg::VAL_W-1:0] key_q;
	logic signed [slt_pkg::VAL_W-1:0] cells_q [slt_pkg::DEPTH];
	logic [slt_pkg::DEPTH-1:0]        lt_c;
	logic [slt_pkg::DEPTH-1:0]        eq_c;
	logic [slt_pkg::DEPTH-1:0]        lt_q;
	logic                             found_q;
	logic [slt_pkg::CNT_W-1:0]        occ_q;
	logic [slt_pkg::CNT_W-1:0]        occ_next;
	logic [slt_pkg::ST_W-1:0]         res_status_q;
	logic [slt_pkg::CNT_W-1:0]        res_count_q;

	// Latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_cmd;
			key_q <= in_value;
		end
	end

	// Per-cell compare against the key, only over occupied cells
	always_comb begin
		for (int i = 0; i < slt_pkg::DEPTH; i++) begin
			lt_c[i] = (slt_pkg::CNT_W'(i) < occ_q) && (cells_q[i] < key_q);
			eq_c[i] = (slt_pkg::CNT_W'(i) < occ_q) && (cells_q[i] == key_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			lt_q    <= lt_c;
			found_q <= |eq_c;
		end
	end

	// Cell row: lt_q is a prefix of ones since the table is sorted.
	// Insert: cells below the slot keep, the slot takes the key, the rest move up.
	// Delete: every cell from the first match on, but the top one, takes its upper neighbor.
	for (genvar i = 0; i < slt_pkg::DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.do_insert && !lt_q[i]) begin
				if (i == 0) begin
					cells_q[i] <= key_q;
				end else if (lt_q[(i == 0) ? 0 : i-1]) begin
					cells_q[i] <= key_q;
				end else begin
					cells_q[i] <= cells_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.do_delete && !lt_q[i] && (i < slt_pkg::DEPTH-1)) begin
				cells_q[i] <= cells_q[(i < slt_pkg::DEPTH-1) ? i+1 : i];
			end
		end
	end

	// Occupancy
	always_comb begin
		occ_next = occ_q;
		if (cmd.do_insert) begin
			occ_next = occ_q + slt_pkg::CNT_W'(1);
		end else if (cmd.do_delete) begin
			occ_next = occ_q - slt_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_next;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			res_status_q <= cmd.res_status;
			res_count_q  <= occ_next;
		end
	end

	assign stat.op    = op_q;
	assign stat.found = found_q;
	assign stat.full  = (occ_q == slt_pkg::CNT_W'(slt_pkg::DEPTH));

	assign res_status = res_status_q;
	assign res_count  = res_count_q;

endmodule

[hdl/slt_ctrl.sv]
// Controller of the sorted list table: sequencing FSM and output valid.
// Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  slt_pkg::dp_stat_t    stat,
	output slt_pkg::dp_cmd_t     cmd
);

	slt_pkg::state_t state_q, state_d;
	logic            m_tvalid_q;
	logic            out_free;

	assign out_free = !m_tvalid_q || m_tready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.res_status = slt_pkg::ST_MISSING;
		case (state_q)
			slt_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = slt_pkg::S_CMP;
				end
			end
			slt_pkg::S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = slt_pkg::S_APPLY;
			end
			slt_pkg::S_APPLY: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_d         = slt_pkg::S_IDLE;
					case (stat.op)
						slt_pkg::CMD_INSERT: begin
							cmd.do_insert  = !stat.full;
							cmd.res_status = stat.full ? slt_pkg::ST_FULL : slt_pkg::ST_INSERTED;
						end
						slt_pkg::CMD_SEARCH: begin
							cmd.res_status = stat.found ? slt_pkg::ST_FOUND : slt_pkg::ST_MISSING;
						end
						slt_pkg::CMD_DELETE: begin
							cmd.do_delete  = stat.found;
							cmd.res_status = stat.found ? slt_pkg::ST_DELETED : slt_pkg::ST_MISSING;
						end
						default: begin
							cmd.res_status = slt_pkg::ST_MISSING;
						end
					endcase
				end
			end
			default: begin
				state_d = slt_pkg::S_IDLE;
			end
		endcase
	end

	// Output valid: set on a new result, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_result) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

[hdl/slt_checker.sv]
// Port-level checks for the sorted list table, bound to the top level.
// Depends on slt_pkg and sorted_list_table_top_defines.svh.
`timescale 1ns / 1ps
`include "sorted_list_table_top_defines.svh"

module slt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// Stalled result holds
	`SLT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

	// One transaction in flight: input closes right after an accept
	`SLT_ASSERT(a_one_inflight, s_tvalid && s_tready |=> !s_tready, "input ready right after accept")

	// Status code stays in range
	`SLT_ASSERT(a_status_range, m_tvalid |-> m_tdata[2:0] <= slt_pkg::ST_FULL, "status code out of range")

	// Refused insert only with a full table
	`SLT_ASSERT(a_full_count, m_tvalid && m_tdata[2:0] == slt_pkg::ST_FULL |-> m_tdata[7:3] == slt_pkg::CNT_W'(slt_pkg::DEPTH), "full status with table not full")

	// No result during reset
	`SLT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind sorted_list_table_top slt_checker u_slt_checker (.*);
